>>> hdl/bba_pkg.sv
package bba_pkg;

    localparam int REGION_LOG2    = 16;
    localparam int MIN_BLOCK_LOG2 = 6;
    localparam int TIER_COUNT     = 11;
    localparam int DEEPEST        = TIER_COUNT - 1;
    localparam int LEAF_LOG2      = REGION_LOG2 - DEEPEST;
    localparam int LEAF_COUNT     = 2 ** DEEPEST;
    localparam int LEAF_AW        = DEEPEST;
    localparam int HEAP_W         = TIER_COUNT;
    localparam int WORD_BITS_LOG2 = 5;
    localparam int WORD_BITS      = 2 ** WORD_BITS_LOG2;
    localparam int WORD_AW        = HEAP_W - WORD_BITS_LOG2;
    localparam int WORD_COUNT     = 2 ** WORD_AW;
    localparam int TIER_W         = 4;
    localparam int OFF_W          = 16;
    localparam int SIZE_W         = 17;
    localparam int OP_W           = 2;
    localparam int STAT_W         = 2;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

    typedef enum logic [4:0] {
        DC_NONE,
        DC_CLEAR,
        DC_LOAD,
        DC_FAIL_OOM,
        DC_FAIL_BAD,
        DC_ALLOC_INIT,
        DC_FREE_INIT,
        DC_TIER_LOAD,
        DC_KEEP,
        DC_FM_READ,
        DC_GROW,
        DC_SCAN,
        DC_PICK,
        DC_SPLIT_ADV,
        DC_SET_UPPER,
        DC_ALLOC_DONE,
        DC_MERGE,
        DC_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic            clr_done;
        logic [OP_W-1:0] op;
        logic            want_ok;
        logic            mark_ok;
        logic            fits;
        logic            grow_ok;
        logic            grow_hit;
        logic            scan_hit;
        logic            pick_hit;
        logic            tier_zero;
        logic            at_want;
        logic            merge_up;
    } dp_stat_t;

endpackage

>>> hdl/bba_dp.sv
module bba_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::dp_cmd_t              cmd,
    output bba_pkg::dp_stat_t             st,
    input  logic [bba_pkg::OP_W-1:0]      opcode,
    input  logic [bba_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     block_offset,
    output logic [bba_pkg::OFF_W-1:0]     result_offset,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic                          moved,
    output logic [bba_pkg::SIZE_W-1:0]    bytes_in_use
);

    logic [bba_pkg::TIER_W:0]           leaf_mem [bba_pkg::LEAF_COUNT];
    logic [bba_pkg::WORD_BITS-1:0]      fm_mem [bba_pkg::WORD_COUNT];

    logic [bba_pkg::OP_W-1:0]           op_reg;
    logic [bba_pkg::SIZE_W-1:0]         size_reg;
    logic [bba_pkg::OFF_W-1:0]          off_reg;
    logic [bba_pkg::TIER_W-1:0]         want_reg;
    logic                               want_ok_reg;
    logic [bba_pkg::TIER_W:0]           leaf_rd_reg;
    logic [bba_pkg::WORD_BITS-1:0]      fm_rd_reg;
    logic [bba_pkg::WORD_COUNT-1:0]     nz_reg;
    logic [bba_pkg::TIER_W-1:0]         t_reg;
    logic [bba_pkg::DEEPEST-1:0]        j_reg;
    logic [bba_pkg::WORD_AW-1:0]        wsel_reg;
    logic [bba_pkg::OFF_W-1:0]          res_reg;
    logic [bba_pkg::STAT_W-1:0]         stat_reg;
    logic                               moved_reg;
    logic [bba_pkg::SIZE_W-1:0]         used_reg;
    logic [bba_pkg::OFF_W-1:0]          out_res_reg;
    logic [bba_pkg::STAT_W-1:0]         out_stat_reg;
    logic                               out_moved_reg;
    logic [bba_pkg::SIZE_W-1:0]         out_used_reg;
    logic [bba_pkg::LEAF_AW-1:0]        clr_cnt_reg;

    logic [bba_pkg::TIER_W-1:0]         want_c;
    logic                               want_ok_c;
    logic [bba_pkg::TIER_W-1:0]         leaf_tier;
    logic [bba_pkg::HEAP_W-1:0]         h_cur;
    logic [bba_pkg::WORD_AW-1:0]        word_cur;
    logic [bba_pkg::WORD_BITS_LOG2-1:0] bit_cur;
    logic [bba_pkg::WORD_BITS_LOG2-1:0] bit_bud;
    logic [bba_pkg::SIZE_W:0]           cur_size;
    logic [bba_pkg::SIZE_W:0]           cur_size2;
    logic [bba_pkg::SIZE_W-1:0]         leaf_size;
    logic [bba_pkg::WORD_COUNT-1:0]     scan_masked;
    logic [bba_pkg::WORD_AW-1:0]        scan_first;
    logic [bba_pkg::WORD_BITS-1:0]      pick_masked;
    logic [bba_pkg::WORD_BITS_LOG2-1:0] pick_first;
    logic [bba_pkg::HEAP_W-1:0]         pick_h;
    logic [bba_pkg::OFF_W-1:0]          alloc_off;
    logic [4:0]                         shamt_cur;
    logic [4:0]                         shamt_leaf;

    logic                               leaf_we;
    logic [bba_pkg::LEAF_AW-1:0]        leaf_wa;
    logic [bba_pkg::TIER_W:0]           leaf_wd;
    logic                               leaf_re;
    logic                               fm_we;
    logic [bba_pkg::WORD_AW-1:0]        fm_wa;
    logic [bba_pkg::WORD_BITS-1:0]      fm_wd;
    logic                               fm_re;
    logic [bba_pkg::WORD_AW-1:0]        fm_ra;

    always_comb
    begin
        logic [bba_pkg::SIZE_W-1:0] sm1;
        int k;
        int tr;
        sm1 = size_bytes - bba_pkg::SIZE_W'(1);
        k = 0;
        for (int i = 0; i < bba_pkg::SIZE_W; i++)
        begin
            if (sm1[i])
            begin
                k = i + 1;
            end
        end
        if (size_bytes <= bba_pkg::SIZE_W'(1))
        begin
            k = 0;
        end
        if (k < bba_pkg::MIN_BLOCK_LOG2)
        begin
            k = bba_pkg::MIN_BLOCK_LOG2;
        end
        want_ok_c = (k <= bba_pkg::REGION_LOG2);
        tr = bba_pkg::REGION_LOG2 - k;
        if (tr > bba_pkg::DEEPEST)
        begin
            tr = bba_pkg::DEEPEST;
        end
        if (tr < 0)
        begin
            tr = 0;
        end
        want_c = bba_pkg::TIER_W'(tr);
    end

    assign leaf_tier  = leaf_rd_reg[bba_pkg::TIER_W-1:0];
    assign h_cur      = (bba_pkg::HEAP_W'(1) << t_reg) | bba_pkg::HEAP_W'(j_reg);
    assign word_cur   = h_cur[bba_pkg::HEAP_W-1:bba_pkg::WORD_BITS_LOG2];
    assign bit_cur    = h_cur[bba_pkg::WORD_BITS_LOG2-1:0];
    assign bit_bud    = bit_cur ^ bba_pkg::WORD_BITS_LOG2'(1);
    assign shamt_cur  = 5'(bba_pkg::REGION_LOG2) - 5'(t_reg);
    assign shamt_leaf = 5'(bba_pkg::REGION_LOG2) - 5'(leaf_tier);
    assign cur_size   = (bba_pkg::SIZE_W+1)'(1) << shamt_cur;
    assign cur_size2  = cur_size << 1;
    assign leaf_size  = bba_pkg::SIZE_W'(1) << shamt_leaf;
    assign alloc_off  = bba_pkg::OFF_W'(j_reg) << shamt_cur;

    always_comb
    begin
        logic [bba_pkg::WORD_COUNT-1:0] m;
        for (int w = 0; w < bba_pkg::WORD_COUNT; w++)
        begin
            if (int'(t_reg) < bba_pkg::WORD_BITS_LOG2)
            begin
                m[w] = (w == 0);
            end
            else
            begin
                m[w] = ((w >> (int'(t_reg) - bba_pkg::WORD_BITS_LOG2)) == 1);
            end
        end
        scan_masked = nz_reg & m;
        scan_first = '0;
        for (int w = bba_pkg::WORD_COUNT - 1; w >= 0; w--)
        begin
            if (scan_masked[w])
            begin
                scan_first = bba_pkg::WORD_AW'(w);
            end
        end
    end

    always_comb
    begin
        logic [bba_pkg::WORD_BITS-1:0] m;
        for (int b = 0; b < bba_pkg::WORD_BITS; b++)
        begin
            if (int'(t_reg) < bba_pkg::WORD_BITS_LOG2)
            begin
                m[b] = ((b >> int'(t_reg)) == 1);
            end
            else
            begin
                m[b] = 1'b1;
            end
        end
        pick_masked = fm_rd_reg & m;
        pick_first = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (pick_masked[b])
            begin
                pick_first = bba_pkg::WORD_BITS_LOG2'(b);
            end
        end
    end

    assign pick_h = {wsel_reg, pick_first};

    always_comb
    begin
        st.clr_done  = (clr_cnt_reg == bba_pkg::LEAF_AW'(bba_pkg::LEAF_COUNT - 1));
        st.op        = op_reg;
        st.want_ok   = want_ok_reg;
        st.mark_ok   = leaf_rd_reg[bba_pkg::TIER_W]
                       && (off_reg[bba_pkg::LEAF_LOG2-1:0] == '0);
        st.fits      = ({1'b0, size_reg} <= cur_size);
        st.grow_ok   = ({1'b0, size_reg} <= cur_size2) && (t_reg != '0) && !j_reg[0];
        st.grow_hit  = fm_rd_reg[bit_bud];
        st.scan_hit  = |scan_masked;
        st.pick_hit  = |pick_masked;
        st.tier_zero = (t_reg == '0);
        st.at_want   = (t_reg == want_reg);
        st.merge_up  = (t_reg != '0) && fm_rd_reg[bit_bud];
    end

    always_comb
    begin
        leaf_we = 1'b0;
        leaf_wa = off_reg[bba_pkg::OFF_W-1:bba_pkg::LEAF_LOG2];
        leaf_wd = '0;
        leaf_re = 1'b0;
        fm_we   = 1'b0;
        fm_wa   = word_cur;
        fm_wd   = fm_rd_reg;
        fm_re   = 1'b0;
        fm_ra   = word_cur;
        case (cmd.op)
            bba_pkg::DC_CLEAR:
            begin
                leaf_we = 1'b1;
                leaf_wa = clr_cnt_reg;
                fm_we   = (int'(clr_cnt_reg) < bba_pkg::WORD_COUNT);
                fm_wa   = bba_pkg::WORD_AW'(clr_cnt_reg);
                fm_wd   = (clr_cnt_reg == '0) ? bba_pkg::WORD_BITS'(2) : '0;
            end
            bba_pkg::DC_LOAD:
            begin
                leaf_re = 1'b1;
            end
            bba_pkg::DC_FREE_INIT:
            begin
                leaf_we = 1'b1;
            end
            bba_pkg::DC_FM_READ:
            begin
                fm_re = 1'b1;
            end
            bba_pkg::DC_GROW:
            begin
                if (fm_rd_reg[bit_bud])
                begin
                    fm_we   = 1'b1;
                    fm_wd   = fm_rd_reg & ~(bba_pkg::WORD_BITS'(1) << bit_bud);
                    leaf_we = 1'b1;
                    leaf_wd = {1'b1, t_reg - bba_pkg::TIER_W'(1)};
                end
            end
            bba_pkg::DC_SCAN:
            begin
                fm_re = |scan_masked;
                fm_ra = scan_first;
            end
            bba_pkg::DC_PICK:
            begin
                fm_we = |pick_masked;
                fm_wa = wsel_reg;
                fm_wd = fm_rd_reg & ~(bba_pkg::WORD_BITS'(1) << pick_first);
            end
            bba_pkg::DC_SET_UPPER:
            begin
                fm_we = 1'b1;
                fm_wd = fm_rd_reg | (bba_pkg::WORD_BITS'(1) << bit_bud);
            end
            bba_pkg::DC_ALLOC_DONE:
            begin
                leaf_we = 1'b1;
                leaf_wa = alloc_off[bba_pkg::OFF_W-1:bba_pkg::LEAF_LOG2];
                leaf_wd = {1'b1, t_reg};
            end
            bba_pkg::DC_MERGE:
            begin
                fm_we = 1'b1;
                if ((t_reg != '0) && fm_rd_reg[bit_bud])
                begin
                    fm_wd = fm_rd_reg & ~(bba_pkg::WORD_BITS'(1) << bit_bud)
                            & ~(bba_pkg::WORD_BITS'(1) << bit_cur);
                end
                else
                begin
                    fm_wd = fm_rd_reg | (bba_pkg::WORD_BITS'(1) << bit_cur);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        if (leaf_re)
        begin
            leaf_rd_reg <= leaf_mem[block_offset[bba_pkg::OFF_W-1:bba_pkg::LEAF_LOG2]];
        end
        if (fm_we)
        begin
            fm_mem[fm_wa] <= fm_wd;
        end
        if (fm_re)
        begin
            fm_rd_reg <= fm_mem[fm_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg      <= bba_pkg::WORD_COUNT'(1);
            clr_cnt_reg <= '0;
            used_reg    <= '0;
        end
        else
        begin
            if (fm_we)
            begin
                nz_reg[fm_wa] <= |fm_wd;
            end
            case (cmd.op)
                bba_pkg::DC_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + bba_pkg::LEAF_AW'(1);
                end
                bba_pkg::DC_FREE_INIT:
                begin
                    used_reg <= used_reg - leaf_size;
                end
                bba_pkg::DC_GROW:
                begin
                    if (fm_rd_reg[bit_bud])
                    begin
                        used_reg <= used_reg + cur_size[bba_pkg::SIZE_W-1:0];
                    end
                end
                bba_pkg::DC_ALLOC_DONE:
                begin
                    used_reg <= used_reg + cur_size[bba_pkg::SIZE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bba_pkg::DC_LOAD:
            begin
                op_reg      <= opcode;
                size_reg    <= size_bytes;
                off_reg     <= block_offset;
                want_reg    <= want_c;
                want_ok_reg <= want_ok_c;
                res_reg     <= '0;
                stat_reg    <= bba_pkg::ST_OK;
                moved_reg   <= 1'b0;
            end
            bba_pkg::DC_FAIL_OOM:
            begin
                res_reg  <= '0;
                stat_reg <= bba_pkg::ST_OOM;
            end
            bba_pkg::DC_FAIL_BAD:
            begin
                res_reg  <= '0;
                stat_reg <= bba_pkg::ST_BAD;
            end
            bba_pkg::DC_ALLOC_INIT:
            begin
                t_reg <= want_reg;
            end
            bba_pkg::DC_TIER_LOAD:
            begin
                t_reg <= leaf_tier;
                j_reg <= bba_pkg::DEEPEST'(off_reg >> shamt_leaf);
            end
            bba_pkg::DC_FREE_INIT:
            begin
                t_reg <= leaf_tier;
                j_reg <= bba_pkg::DEEPEST'(off_reg >> shamt_leaf);
                if (op_reg == bba_pkg::OP_FREE)
                begin
                    res_reg <= off_reg;
                end
            end
            bba_pkg::DC_KEEP:
            begin
                res_reg <= off_reg;
            end
            bba_pkg::DC_GROW:
            begin
                if (fm_rd_reg[bit_bud])
                begin
                    res_reg <= off_reg;
                end
            end
            bba_pkg::DC_SCAN:
            begin
                if (|scan_masked)
                begin
                    wsel_reg <= scan_first;
                end
                else if (t_reg != '0)
                begin
                    t_reg <= t_reg - bba_pkg::TIER_W'(1);
                end
            end
            bba_pkg::DC_PICK:
            begin
                if (|pick_masked)
                begin
                    j_reg <= bba_pkg::DEEPEST'(pick_h & ~(bba_pkg::HEAP_W'(1) << t_reg));
                end
                else if (t_reg != '0)
                begin
                    t_reg <= t_reg - bba_pkg::TIER_W'(1);
                end
            end
            bba_pkg::DC_SPLIT_ADV:
            begin
                t_reg <= t_reg + bba_pkg::TIER_W'(1);
                j_reg <= j_reg << 1;
            end
            bba_pkg::DC_ALLOC_DONE:
            begin
                res_reg   <= alloc_off;
                moved_reg <= (op_reg == bba_pkg::OP_REALLOC);
            end
            bba_pkg::DC_MERGE:
            begin
                if ((t_reg != '0) && fm_rd_reg[bit_bud])
                begin
                    t_reg <= t_reg - bba_pkg::TIER_W'(1);
                    j_reg <= j_reg >> 1;
                end
            end
            bba_pkg::DC_EMIT:
            begin
                out_res_reg   <= res_reg;
                out_stat_reg  <= stat_reg;
                out_moved_reg <= moved_reg;
                out_used_reg  <= used_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result_offset = out_res_reg;
    assign status        = out_stat_reg;
    assign moved         = out_moved_reg;
    assign bytes_in_use  = out_used_reg;

endmodule

>>> hdl/bba_ctrl.sv
module bba_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bba_pkg::dp_cmd_t  cmd,
    input  bba_pkg::dp_stat_t st
);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_CHECK  = 16'h0004,
        S_RDEC   = 16'h0008,
        S_GROW   = 16'h0010,
        S_ASTART = 16'h0020,
        S_SCAN   = 16'h0040,
        S_PICK   = 16'h0080,
        S_OOM    = 16'h0100,
        S_SPLIT  = 16'h0200,
        S_SPL_RD = 16'h0400,
        S_SPL_WR = 16'h0800,
        S_MFREE  = 16'h1000,
        S_MRG_RD = 16'h2000,
        S_MRG    = 16'h4000,
        S_DONE   = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = bba_pkg::DC_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = bba_pkg::DC_CLEAR;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = bba_pkg::DC_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.op == bba_pkg::OP_ALLOC)
                begin
                    state_next = S_ASTART;
                end
                else if (st.op == bba_pkg::OP_FREE && st.mark_ok)
                begin
                    cmd.op     = bba_pkg::DC_FREE_INIT;
                    state_next = S_MRG_RD;
                end
                else if (st.op == bba_pkg::OP_REALLOC && st.mark_ok)
                begin
                    cmd.op     = bba_pkg::DC_TIER_LOAD;
                    state_next = S_RDEC;
                end
                else
                begin
                    cmd.op     = bba_pkg::DC_FAIL_BAD;
                    state_next = S_DONE;
                end
            end
            S_RDEC:
            begin
                if (st.fits)
                begin
                    cmd.op     = bba_pkg::DC_KEEP;
                    state_next = S_DONE;
                end
                else if (st.grow_ok)
                begin
                    cmd.op     = bba_pkg::DC_FM_READ;
                    state_next = S_GROW;
                end
                else
                begin
                    state_next = S_ASTART;
                end
            end
            S_GROW:
            begin
                cmd.op     = bba_pkg::DC_GROW;
                state_next = st.grow_hit ? S_DONE : S_ASTART;
            end
            S_ASTART:
            begin
                if (st.want_ok)
                begin
                    cmd.op     = bba_pkg::DC_ALLOC_INIT;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.op     = bba_pkg::DC_FAIL_OOM;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.op = bba_pkg::DC_SCAN;
                if (st.scan_hit)
                begin
                    state_next = S_PICK;
                end
                else if (st.tier_zero)
                begin
                    state_next = S_OOM;
                end
            end
            S_PICK:
            begin
                cmd.op = bba_pkg::DC_PICK;
                if (st.pick_hit)
                begin
                    state_next = S_SPLIT;
                end
                else if (st.tier_zero)
                begin
                    state_next = S_OOM;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_OOM:
            begin
                cmd.op     = bba_pkg::DC_FAIL_OOM;
                state_next = S_DONE;
            end
            S_SPLIT:
            begin
                if (st.at_want)
                begin
                    cmd.op     = bba_pkg::DC_ALLOC_DONE;
                    state_next = (st.op == bba_pkg::OP_REALLOC) ? S_MFREE : S_DONE;
                end
                else
                begin
                    cmd.op     = bba_pkg::DC_SPLIT_ADV;
                    state_next = S_SPL_RD;
                end
            end
            S_SPL_RD:
            begin
                cmd.op     = bba_pkg::DC_FM_READ;
                state_next = S_SPL_WR;
            end
            S_SPL_WR:
            begin
                cmd.op     = bba_pkg::DC_SET_UPPER;
                state_next = S_SPLIT;
            end
            S_MFREE:
            begin
                cmd.op     = bba_pkg::DC_FREE_INIT;
                state_next = S_MRG_RD;
            end
            S_MRG_RD:
            begin
                cmd.op     = bba_pkg::DC_FM_READ;
                state_next = S_MRG;
            end
            S_MRG:
            begin
                cmd.op     = bba_pkg::DC_MERGE;
                state_next = st.merge_up ? S_MRG_RD : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.op     = bba_pkg::DC_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == bba_pkg::DC_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/buddy_block_allocator.sv
// Buddy allocator over a 64 KiB region, minimum block 64 bytes, eleven tiers.
// Input channel (in_valid / in_stall) takes one request word: opcode,
// size_bytes and block_offset. Output channel (out_valid / out_stall) gives
// one result word per request: result_offset, status, moved, bytes_in_use.
// One request is in work at a time; the next is taken the cycle after its
// result has been moved to the output register, even while that result waits.
// A bad offset or opcode fails at the check; a reallocate that fits keeps its
// block, or grows in place into a free buddy; a free merges with free buddies
// one tier at a time; an allocate searches from the wanted tier toward larger
// blocks, then splits the block it finds down to the wanted tier; a moving
// reallocate adds the size check, then frees its old block after the allocate.
// The free-map scan, split and merge each walk one tier at a time over a
// single-port free-map memory.
// After reset the block sweeps its leaf table and free map, one entry a
// cycle, with in_stall high; then the whole region is free.
// While out_stall is high the result holds; a finished request waits until
// the output register frees.
module buddy_block_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bba_pkg::OP_W-1:0]      opcode,
    input  logic [bba_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [bba_pkg::OFF_W-1:0]     block_offset,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bba_pkg::OFF_W-1:0]     result_offset,
    output logic [bba_pkg::STAT_W-1:0]    status,
    output logic                          moved,
    output logic [bba_pkg::SIZE_W-1:0]    bytes_in_use
);

    bba_pkg::dp_cmd_t  cmd;
    bba_pkg::dp_stat_t st;

    bba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    bba_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .opcode        (opcode),
        .size_bytes    (size_bytes),
        .block_offset  (block_offset),
        .result_offset (result_offset),
        .status        (status),
        .moved         (moved),
        .bytes_in_use  (bytes_in_use)
    );

endmodule
